// ----- design/pixel_color_grade_assert.svh -----
// Assertion macros shared by the grading pipeline.
`ifndef PIXEL_COLOR_GRADE_ASSERT_SVH
`define PIXEL_COLOR_GRADE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PCG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PCG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/pcg_pkg.sv -----
`default_nettype none

package pcg_pkg;

	localparam int FRAC_BITS         = 12;
	localparam int ONE_Q             = 1 << FRAC_BITS;
	localparam int EPS_Q             = (ONE_Q + 9999) / 10000;
	localparam int CURVE_ENTRIES_DEF = 256;
	localparam int DIV_STEPS         = 24;

	// configuration register indexes
	localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
	localparam logic [1:0] REG_CONTRAST   = 2'd1;
	localparam logic [1:0] REG_SAT_GAIN   = 2'd2;

	localparam logic [13:0] SAT_GAIN_RST = 14'd4096;

	// request kinds on tuser
	localparam logic REQ_GRADE = 1'b0;
	localparam logic REQ_LOAD  = 1'b1;

	// curve table selectors
	localparam logic [1:0] CURVE_MASTER = 2'd0;
	localparam logic [1:0] CURVE_RED    = 2'd1;
	localparam logic [1:0] CURVE_GREEN  = 2'd2;
	localparam logic [1:0] CURVE_BLUE   = 2'd3;

	// channel that holds the maximum, picks the hue formula
	localparam logic [1:0] HUE_RED   = 2'd0;
	localparam logic [1:0] HUE_GREEN = 2'd1;
	localparam logic [1:0] HUE_BLUE  = 2'd2;

	typedef struct packed {
		logic        vld;
		logic        ld;
		logic [1:0]  sel;
		logic [7:0]  idx;
		logic [12:0] val;
		logic [12:0] alpha;
	} pcg_side_t;

	typedef struct packed {
		pcg_side_t          side;
		logic signed [15:0] v;
		logic [1:0]         hsec;
		logic               dark;
		logic               grey;
		logic               big;
		logic               neg;
	} pcg_ctx_t;

endpackage

`default_nettype wire

// ----- design/pixel_color_grade.sv -----
// Color grading pipeline: one RGBA pixel or one curve load per clock, sustained while the
// output skid is empty. The pipeline holds two 24-step restoring dividers (saturation and
// hue) that run side by side, one quotient bit a stage, plus the four curve tables read in
// order (master, then per channel). Curve loads travel the same pipeline and write each
// table at the stage where pixels read it, so a pixel sees every load accepted before it
// and none after. Loads give no output beat. The output holds one beat plus one skid beat,
// so input is still taken while a result waits. Configuration must be written only while
// the pipeline is empty; the block itself does not enforce this.
`default_nettype none

`include "pixel_color_grade_assert.svh"

module pixel_color_grade import pcg_pkg::*; #(
	parameter int CURVE_ENTRIES = CURVE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [13:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// red_in, green_in, blue_in, alpha_in, curve_select, curve_index, curve_value
	input  logic [79:0] s_tdata,
	// req_type
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// red_out, green_out, blue_out, alpha_out
	output logic [55:0] m_tdata
);

	localparam int AW = (CURVE_ENTRIES > 1) ? $clog2(CURVE_ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(CURVE_ENTRIES - 1);
	localparam logic [AW+7:0] ENTRIES_W = (AW+8)'(CURVE_ENTRIES);

	// configuration
	logic [13:0] br_q, ct_q, sg_q;
	logic signed [13:0] br_c, ct_c;
	logic signed [14:0] fac_w;
	logic [13:0] fac_c, gain_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_q <= '0;
			ct_q <= '0;
			sg_q <= SAT_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BRIGHTNESS: br_q <= cfg_wdata;
				REG_CONTRAST:   ct_q <= cfg_wdata;
				REG_SAT_GAIN:   sg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if ($signed(br_q) > 14'sd4096) br_c = 14'sd4096;
		else if ($signed(br_q) < -14'sd4096) br_c = -14'sd4096;
		else br_c = $signed(br_q);
		if ($signed(ct_q) > 14'sd4096) ct_c = 14'sd4096;
		else if ($signed(ct_q) < -14'sd4096) ct_c = -14'sd4096;
		else ct_c = $signed(ct_q);
		fac_w  = 15'(ct_c) + 15'sd4096;
		fac_c  = fac_w[13:0];
		gain_c = (sg_q > 14'd8192) ? 14'd8192 : sg_q;
	end

	// flow control
	logic en;
	logic out_v_q, skid_v_q;
	logic [51:0] out_q, skid_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	// s1: input beat
	pcg_side_t side_s1;
	logic [12:0] rgb_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1.vld   <= s_tvalid;
			side_s1.ld    <= (s_tuser == REQ_LOAD);
			side_s1.alpha <= s_tdata[51:39];
			side_s1.sel   <= s_tdata[53:52];
			side_s1.idx   <= s_tdata[61:54];
			side_s1.val   <= s_tdata[74:62];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_s1[0] <= s_tdata[12:0];
			rgb_s1[1] <= s_tdata[25:13];
			rgb_s1[2] <= s_tdata[38:26];
		end
	end

	// s2: brightness, then contrast product about one half
	pcg_side_t side_s2;
	logic signed [30:0] cp_s2 [3];
	logic signed [14:0] bx [3];
	logic signed [15:0] bxm [3];
	logic signed [30:0] cp_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			bx[k]   = $signed({2'b00, rgb_s1[k]}) + 15'(br_c);
			bxm[k]  = 16'(bx[k]) - 16'sd2048;
			cp_c[k] = bxm[k] * $signed({1'b0, fac_c});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s2 <= '0;
		else if (en) side_s2 <= side_s1;
	end

	always_ff @(posedge clk) begin
		if (en) cp_s2 <= cp_c;
	end

	// s3: scale down and saturate to Q3.12
	pcg_side_t side_s3;
	logic signed [15:0] c_s3 [3];
	logic signed [18:0] cy [3];
	logic signed [15:0] cc_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cy[k] = 19'(cp_s2[k] >>> FRAC_BITS) + 19'sd2048;
			if (cy[k] > 19'sd32767) cc_c[k] = 16'sh7FFF;
			else if (cy[k] < -19'sd32768) cc_c[k] = 16'sh8000;
			else cc_c[k] = cy[k][15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s3 <= '0;
		else if (en) side_s3 <= side_s2;
	end

	always_ff @(posedge clk) begin
		if (en) c_s3 <= cc_c;
	end

	// s4 group: max/min, then two restoring dividers (lane 0 saturation, lane 1 hue)
	logic signed [15:0] mx, mn;
	logic signed [16:0] dl17, df17;
	logic [15:0] delta, absd;
	logic [1:0] hsec;
	logic dark, grey, big;
	logic [27:0] n_c [2];
	logic [15:0] d_c [2];

	always_comb begin
		mx = c_s3[0];
		mn = c_s3[0];
		for (int k = 1; k < 3; k++) begin
			if (c_s3[k] > mx) mx = c_s3[k];
			if (c_s3[k] < mn) mn = c_s3[k];
		end
		if (mx == c_s3[0]) hsec = HUE_RED;
		else if (mx == c_s3[1]) hsec = HUE_GREEN;
		else hsec = HUE_BLUE;
		dl17  = 17'(mx) - 17'(mn);
		delta = dl17[15:0];
		case (hsec)
			HUE_RED:   df17 = 17'(c_s3[1]) - 17'(c_s3[2]);
			HUE_GREEN: df17 = 17'(c_s3[2]) - 17'(c_s3[0]);
			default:   df17 = 17'(c_s3[0]) - 17'(c_s3[1]);
		endcase
		absd = df17[16] ? 16'(-df17) : df17[15:0];
		dark = (mx < $signed(16'(EPS_Q)));
		grey = (delta < 16'(EPS_Q));
		big  = ({11'b0, delta} >= {mx[14:0], 12'b0});
		n_c[0] = {delta, 12'b0};
		d_c[0] = dark ? 16'd1 : mx;
		n_c[1] = {absd, 12'b0};
		d_c[1] = grey ? 16'd1 : delta;
	end

	pcg_ctx_t dv_ctx_s4 [DIV_STEPS+1];
	logic [15:0] dv_rem_s4 [DIV_STEPS+1][2];
	logic [23:0] dv_num_s4 [DIV_STEPS+1][2];
	logic [15:0] dv_den_s4 [DIV_STEPS+1][2];
	logic [23:0] dv_quo_s4 [DIV_STEPS+1][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_ctx_s4[0] <= '0;
		end else if (en) begin
			dv_ctx_s4[0].side <= side_s3;
			dv_ctx_s4[0].v    <= mx;
			dv_ctx_s4[0].hsec <= hsec;
			dv_ctx_s4[0].dark <= dark;
			dv_ctx_s4[0].grey <= grey;
			dv_ctx_s4[0].big  <= big;
			dv_ctx_s4[0].neg  <= df17[16];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				dv_rem_s4[0][l] <= {12'b0, n_c[l][27:24]};
				dv_num_s4[0][l] <= n_c[l][23:0];
				dv_den_s4[0][l] <= d_c[l];
				dv_quo_s4[0][l] <= '0;
			end
		end
	end

	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		logic [16:0] trial [2];
		logic ge [2];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				trial[l] = {dv_rem_s4[j-1][l], dv_num_s4[j-1][l][23]};
				ge[l]    = (trial[l] >= {1'b0, dv_den_s4[j-1][l]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_ctx_s4[j] <= '0;
			else if (en) dv_ctx_s4[j] <= dv_ctx_s4[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 2; l++) begin
					dv_rem_s4[j][l] <= ge[l] ? 16'(trial[l] - {1'b0, dv_den_s4[j-1][l]})
						: trial[l][15:0];
					dv_num_s4[j][l] <= {dv_num_s4[j-1][l][22:0], 1'b0};
					dv_den_s4[j][l] <= dv_den_s4[j-1][l];
					dv_quo_s4[j][l] <= {dv_quo_s4[j-1][l][22:0], ge[l]};
				end
			end
		end
	end

	// s5: saturation times gain, hue assembly
	pcg_ctx_t ctx_s5;
	logic [37:0] sp_s5;
	logic [14:0] hue_s5;
	pcg_ctx_t dctx;
	logic [13:0] hmag;
	logic signed [14:0] qh;
	logic signed [16:0] hsum;
	logic [14:0] hue_c;

	assign dctx = dv_ctx_s4[DIV_STEPS];

	always_comb begin
		hmag = {1'b0, dv_quo_s4[DIV_STEPS][1][12:0]}
			+ {13'b0, dctx.neg & (|dv_rem_s4[DIV_STEPS][1])};
		qh = dctx.neg ? -$signed({1'b0, hmag}) : $signed({1'b0, hmag});
		case (dctx.hsec)
			HUE_RED:   hsum = 17'(qh) + ((qh < 0) ? 17'sd24576 : 17'sd0);
			HUE_GREEN: hsum = 17'(qh) + 17'sd8192;
			default:   hsum = 17'(qh) + 17'sd16384;
		endcase
		if (dctx.grey || dctx.dark || hsum < 0) hue_c = '0;
		else if (hsum > 17'sd24575) hue_c = 15'd24575;
		else hue_c = hsum[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctx_s5 <= '0;
		else if (en) ctx_s5 <= dctx;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s5  <= 38'(dv_quo_s4[DIV_STEPS][0]) * 38'(gain_c);
			hue_s5 <= hue_c;
		end
	end

	// s6: clamp saturation to 0..1
	pcg_side_t side_s6;
	logic signed [15:0] v_s6;
	logic [12:0] s_s6;
	logic [14:0] hue_s6;
	logic [12:0] s_c;

	always_comb begin
		if (ctx_s5.dark) s_c = '0;
		else if (ctx_s5.big) s_c = (gain_c != '0) ? 13'd4096 : 13'd0;
		else if (sp_s5[37:12] > 26'd4096) s_c = 13'd4096;
		else s_c = sp_s5[24:12];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s6 <= '0;
		else if (en) side_s6 <= ctx_s5.side;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s6   <= ctx_s5.v;
			s_s6   <= s_c;
			hue_s6 <= hue_s5;
		end
	end

	// s7: s*f, s*(1-f), v*(1-s)
	pcg_side_t side_s7;
	logic signed [15:0] v_s7;
	logic [24:0] sf_s7;
	logic [25:0] sfc_s7;
	logic [27:0] pp_s7;
	logic [2:0] sec_s7;
	logic low_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s7 <= '0;
		else if (en) side_s7 <= side_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s7   <= v_s6;
			sf_s7  <= 25'(s_s6) * 25'(hue_s6[11:0]);
			sfc_s7 <= 26'(s_s6) * 26'(13'd4096 - {1'b0, hue_s6[11:0]});
			pp_s7  <= 28'(v_s6[14:0]) * 28'(13'd4096 - s_s6);
			sec_s7 <= hue_s6[14:12];
			low_s7 <= (s_s6 < 13'(EPS_Q));
		end
	end

	// s8: p, and the q and t products
	pcg_side_t side_s8;
	logic signed [15:0] v_s8;
	logic [14:0] p_s8;
	logic [27:0] qp_s8, tp_s8;
	logic [2:0] sec_s8;
	logic low_s8;
	logic [12:0] a1, a2;

	always_comb begin
		a1 = 13'd4096 - sf_s7[24:12];
		a2 = 13'd4096 - sfc_s7[24:12];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s8 <= '0;
		else if (en) side_s8 <= side_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s8   <= v_s7;
			p_s8   <= pp_s7[26:12];
			qp_s8  <= 28'(v_s7[14:0]) * 28'(a1);
			tp_s8  <= 28'(v_s7[14:0]) * 28'(a2);
			sec_s8 <= sec_s7;
			low_s8 <= low_s7;
		end
	end

	// s9: sextant select, clamp to 0..1
	pcg_side_t side_s9;
	logic [12:0] cc_s9 [3];
	logic signed [15:0] hp, hq, ht;
	logic signed [15:0] hc [3];
	logic [12:0] hc_cl [3];

	always_comb begin
		hp = $signed({1'b0, p_s8});
		hq = $signed({1'b0, qp_s8[26:12]});
		ht = $signed({1'b0, tp_s8[26:12]});
		if (low_s8) begin
			hc[0] = v_s8; hc[1] = v_s8; hc[2] = v_s8;
		end else begin
			case (sec_s8)
				3'd0: begin hc[0] = v_s8; hc[1] = ht;   hc[2] = hp;   end
				3'd1: begin hc[0] = hq;   hc[1] = v_s8; hc[2] = hp;   end
				3'd2: begin hc[0] = hp;   hc[1] = v_s8; hc[2] = ht;   end
				3'd3: begin hc[0] = hp;   hc[1] = hq;   hc[2] = v_s8; end
				3'd4: begin hc[0] = ht;   hc[1] = hp;   hc[2] = v_s8; end
				default: begin hc[0] = v_s8; hc[1] = hp; hc[2] = hq; end
			endcase
		end
		for (int k = 0; k < 3; k++) begin
			if (hc[k] < 0) hc_cl[k] = '0;
			else if (hc[k] > 16'sd4096) hc_cl[k] = 13'd4096;
			else hc_cl[k] = hc[k][12:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s9 <= '0;
		else if (en) side_s9 <= side_s8;
	end

	always_ff @(posedge clk) begin
		if (en) cc_s9 <= hc_cl;
	end

	// s10/s11: curve memories; loads write where pixels read, keeping stream order
	pcg_side_t side_s10, side_s11;
	logic [12:0] mst_s10 [3];
	logic [12:0] chn_s11 [3];
	logic [AW+7:0] wext_s9, wext_s10;
	logic mwr_s9, cld_s10;

	always_comb begin
		wext_s9  = {{AW{1'b0}}, side_s9.idx};
		wext_s10 = {{AW{1'b0}}, side_s10.idx};
		mwr_s9   = en && side_s9.vld && side_s9.ld && (side_s9.sel == CURVE_MASTER)
			&& (wext_s9 < ENTRIES_W);
		cld_s10  = en && side_s10.vld && side_s10.ld && (wext_s10 < ENTRIES_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s10 <= '0;
			side_s11 <= '0;
		end else if (en) begin
			side_s10 <= side_s9;
			side_s11 <= side_s10;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_chan
		logic [12:0] mst_mem [CURVE_ENTRIES];
		logic [12:0] chn_mem [CURVE_ENTRIES];
		logic [AW+12:0] mprod, cprod;
		logic [AW-1:0] maddr, caddr;
		logic [12:0] mcl;

		always_comb begin
			mprod = (AW+13)'(cc_s9[k]) * (AW+13)'(CURVE_ENTRIES - 1);
			maddr = (mprod[AW+11:12] > LAST_IDX) ? LAST_IDX : mprod[AW+11:12];
			mcl   = (mst_s10[k] > 13'd4096) ? 13'd4096 : mst_s10[k];
			cprod = (AW+13)'(mcl) * (AW+13)'(CURVE_ENTRIES - 1);
			caddr = (cprod[AW+11:12] > LAST_IDX) ? LAST_IDX : cprod[AW+11:12];
		end

		always_ff @(posedge clk) begin
			if (mwr_s9) mst_mem[wext_s9[AW-1:0]] <= side_s9.val;
			if (en) mst_s10[k] <= mst_mem[maddr];
		end

		always_ff @(posedge clk) begin
			if (cld_s10 && (side_s10.sel == 2'(k + 1))) chn_mem[wext_s10[AW-1:0]] <= side_s10.val;
			if (en) chn_s11[k] <= chn_mem[caddr];
		end
	end

	// output register and skid
	logic pix_last, take;
	logic [51:0] pix_data;
	logic [12:0] fin [3];

	always_comb begin
		for (int k = 0; k < 3; k++) fin[k] = (chn_s11[k] > 13'd4096) ? 13'd4096 : chn_s11[k];
		pix_data = {side_s11.alpha, fin[2], fin[1], fin[0]};
		pix_last = side_s11.vld && !side_s11.ld;
		take     = out_v_q && m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) skid_v_q <= 1'b0;
		end else if (pix_last) begin
			if (out_v_q && !take) skid_v_q <= 1'b1;
			else out_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) out_q <= skid_q;
		end else if (pix_last) begin
			if (out_v_q && !take) skid_q <= pix_data;
			else out_q <= pix_data;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'b0, out_q};

	`PCG_ASSERT_NOW(a_skid_needs_out, skid_v_q, out_v_q, "skid holds a beat with output empty")
	`PCG_ASSERT_NEXT(a_skid_drains, skid_v_q && m_tready, out_v_q && !skid_v_q,
		"skid beat not moved to output")
	`PCG_ASSERT_NEXT(a_pix_to_skid, en && pix_last && out_v_q && !m_tready, skid_v_q,
		"graded pixel dropped at full output")
	`PCG_ASSERT_NOW(a_out_range, m_tvalid,
		m_tdata[12:0] <= 13'd4096 && m_tdata[25:13] <= 13'd4096
		&& m_tdata[38:26] <= 13'd4096, "graded component above one")

endmodule

`default_nettype wire

// ----- sim/pixel_color_grade_test.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pixel_color_grade_test;
	import pcg_pkg::*;

	localparam int LATENCY   = 40;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		logic [12:0] red;
		logic [12:0] green;
		logic [12:0] blue;
		logic [12:0] alpha;
	} pixel_t;

	typedef struct {
		logic        kind;
		logic [1:0]  sel;
		logic [7:0]  idx;
		logic [12:0] val;
		pixel_t      px;
		logic        typed;
		pixel_t      want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [13:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        s_tuser = REQ_GRADE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;

	pixel_color_grade dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [12:0] curve_mem [4][256];
	logic [13:0] bright_reg, contrast_reg, gain_reg;
	pixel_t      graded_q[$];
	int          fail_cnt = 0;
	int          idle_cycles = 0;
	bit          quiet = 1'b0;
	int          stall_left = 0;

	function automatic longint clampq(longint x, longint lo, longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	function automatic longint floor_div(longint n, longint d);
		longint qt;
		qt = n / d;
		if ((n % d) != 0 && n < 0) qt--;
		return qt;
	endfunction

	function automatic longint curve_lookup(int sel, longint c);
		longint idx;
		idx = (c * 255) >>> FRAC_BITS;
		if (idx > 255) idx = 255;
		return clampq(longint'(curve_mem[sel][idx]), 0, ONE_Q);
	endfunction

	function automatic pixel_t grade_pixel(pixel_t px);
		longint c[3], br, fac, gn, mx, mn, dl, s, h, f, p, q, t, v, x;
		int sec;
		pixel_t res;
		br  = clampq(longint'($signed(bright_reg)), -ONE_Q, ONE_Q);
		fac = clampq(longint'($signed(contrast_reg)), -ONE_Q, ONE_Q) + ONE_Q;
		gn  = clampq(longint'(gain_reg), 0, 2 * ONE_Q);
		c[0] = px.red;
		c[1] = px.green;
		c[2] = px.blue;
		for (int k = 0; k < 3; k++) begin
			x = clampq(c[k] + br, -8 * ONE_Q, 8 * ONE_Q - 1);
			x = (((x - ONE_Q / 2) * fac) >>> FRAC_BITS) + ONE_Q / 2;
			c[k] = clampq(x, -8 * ONE_Q, 8 * ONE_Q - 1);
		end
		mx = c[0];
		mn = c[0];
		for (int k = 1; k < 3; k++) begin
			if (c[k] > mx) mx = c[k];
			if (c[k] < mn) mn = c[k];
		end
		dl = mx - mn;
		v = mx;
		s = 0;
		h = 0;
		if (mx >= EPS_Q) begin
			s = floor_div(dl * ONE_Q, mx);
			if (dl >= EPS_Q) begin
				// red wins ties, then green
				if (mx == c[0]) begin
					h = floor_div((c[1] - c[2]) * ONE_Q, dl);
					if (h < 0) h += 6 * ONE_Q;
				end else if (mx == c[1]) begin
					h = 2 * ONE_Q + floor_div((c[2] - c[0]) * ONE_Q, dl);
				end else begin
					h = 4 * ONE_Q + floor_div((c[0] - c[1]) * ONE_Q, dl);
				end
			end
		end
		s = clampq((s * gn) >>> FRAC_BITS, 0, ONE_Q);
		if (s < EPS_Q) begin
			c[0] = v;
			c[1] = v;
			c[2] = v;
		end else begin
			h = clampq(h, 0, 6 * ONE_Q - 1);
			sec = int'(h >>> FRAC_BITS);
			f = h & (ONE_Q - 1);
			p = (v * (ONE_Q - s)) >>> FRAC_BITS;
			q = (v * (ONE_Q - ((s * f) >>> FRAC_BITS))) >>> FRAC_BITS;
			t = (v * (ONE_Q - ((s * (ONE_Q - f)) >>> FRAC_BITS))) >>> FRAC_BITS;
			case (sec)
				0: begin c[0] = v; c[1] = t; c[2] = p; end
				1: begin c[0] = q; c[1] = v; c[2] = p; end
				2: begin c[0] = p; c[1] = v; c[2] = t; end
				3: begin c[0] = p; c[1] = q; c[2] = v; end
				4: begin c[0] = t; c[1] = p; c[2] = v; end
				default: begin c[0] = v; c[1] = p; c[2] = q; end
			endcase
		end
		for (int k = 0; k < 3; k++) begin
			x = curve_lookup(CURVE_MASTER, clampq(c[k], 0, ONE_Q));
			c[k] = clampq(curve_lookup(k + 1, x), 0, ONE_Q);
		end
		res.red   = c[0][12:0];
		res.green = c[1][12:0];
		res.blue  = c[2][12:0];
		res.alpha = px.alpha;
		return res;
	endfunction

	// one beat into the block; typed rows bring their own expectation
	task automatic send_beat(logic kind, logic [1:0] sel, logic [7:0] idx,
			logic [12:0] val, pixel_t px, logic typed, pixel_t want);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {5'b0, val, idx, sel, px.alpha, px.blue, px.green, px.red};
		do @(posedge clk); while (!s_tready);
		if (kind == REQ_LOAD) curve_mem[sel][idx] = val;
		else graded_q.push_back(typed ? want : grade_pixel(px));
		@(negedge clk);
	endtask

	task automatic set_regs(logic [13:0] b, logic [13:0] c, logic [13:0] g);
		s_tvalid <= 1'b0;
		wait (graded_q.size() == 0);
		repeat (LATENCY) @(negedge clk);
		cfg_we <= 1'b1; cfg_addr <= REG_BRIGHTNESS; cfg_wdata <= b;
		@(negedge clk);
		cfg_addr <= REG_CONTRAST; cfg_wdata <= c;
		@(negedge clk);
		cfg_addr <= REG_SAT_GAIN; cfg_wdata <= g;
		@(negedge clk);
		cfg_we <= 1'b0;
		bright_reg = b;
		contrast_reg = c;
		gain_reg = g;
	endtask

	task automatic random_beat();
		pixel_t px;
		logic [12:0] val;
		logic [1:0] sel;
		if ($urandom_range(0, 6) == 0) begin
			sel = 2'($urandom);
			// keep master values on the grid whose channel entries are filled
			if (sel == CURVE_MASTER)
				val = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(ONE_Q + 1, 8191))
					: 13'($urandom_range(0, 16) * 256);
			else
				val = ($urandom_range(0, 7) == 0) ? 13'($urandom)
					: 13'($urandom_range(0, ONE_Q));
			send_beat(REQ_LOAD, sel, 8'($urandom), val, pixel_t'($urandom),
				1'b0, '0);
		end else begin
			case ($urandom_range(0, 9))
				0: px = {13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom)};
				1: begin
					px.red = 13'($urandom_range(0, 8));
					px.green = px.red;
					px.blue = 13'($urandom_range(0, 8));
				end
				2: begin
					px.red = 13'($urandom_range(0, ONE_Q));
					px.green = px.red;
					px.blue = ($urandom_range(0, 1) == 1) ? px.red : 13'($urandom_range(0, ONE_Q));
				end
				default: begin
					px.red = 13'($urandom_range(0, ONE_Q));
					px.green = 13'($urandom_range(0, ONE_Q));
					px.blue = 13'($urandom_range(0, ONE_Q));
				end
			endcase
			px.alpha = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, ONE_Q));
			send_beat(REQ_GRADE, 2'($urandom), 8'($urandom), 13'($urandom), px, 1'b0, '0);
		end
	endtask

	task automatic check_field(string name, logic [12:0] want, logic [12:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk) begin
		pixel_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[12:0], m_tdata[25:13], m_tdata[38:26], m_tdata[51:39]};
			if (graded_q.size() == 0) begin
				$error("unexpected output beat");
				fail_cnt++;
			end else begin
				want = graded_q.pop_front();
				check_field("red_out", want.red, got.red);
				check_field("green_out", want.green, got.green);
				check_field("blue_out", want.blue, got.blue);
				check_field("alpha_out", want.alpha, got.alpha);
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 11);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// count cycles with no beat moving on either side and no configuration write
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** pixel_color_grade: FAILED **");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		logic [13:0] cfg_set [8][3];
		bright_reg = 14'd0;
		contrast_reg = 14'd0;
		gain_reg = SAT_GAIN_RST;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// master table as a staircase in steps of 256, so a pixel only reaches
		// the channel entries written below
		for (int i = 0; i < 256; i++)
			send_beat(REQ_LOAD, CURVE_MASTER, 8'(i), 13'((i >> 4) * 256), '0, 1'b0, '0);
		for (int t = 1; t < 4; t++)
			for (int m = 0; m <= 16; m++)
				send_beat(REQ_LOAD, 2'(t), 8'((m * 255) / 16), 13'(((m * 255) / 16) * 16),
					'0, 1'b0, '0);

		rows = '{
			'{REQ_GRADE, CURVE_MASTER, 8'd0, 13'd0, '{13'd0, 13'd0, 13'd0, 13'd4096},
				1'b1, '{13'd0, 13'd0, 13'd0, 13'd4096}},
			'{REQ_GRADE, CURVE_MASTER, 8'd0, 13'd0, '{13'd4096, 13'd4096, 13'd4096, 13'd0},
				1'b1, '{13'd3824, 13'd3824, 13'd3824, 13'd0}},
			'{REQ_GRADE, CURVE_RED, 8'd0, 13'd0, '{13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF},
				1'b0, '0},
			'{REQ_GRADE, CURVE_MASTER, 8'd0, 13'd0, '{13'd4096, 13'd0, 13'd0, 13'd100},
				1'b0, '0},
			'{REQ_GRADE, CURVE_MASTER, 8'd0, 13'd0, '{13'd0, 13'd4096, 13'd0, 13'd100},
				1'b0, '0},
			'{REQ_GRADE, CURVE_MASTER, 8'd0, 13'd0, '{13'd0, 13'd0, 13'd4096, 13'd100},
				1'b0, '0},
			'{REQ_GRADE, CURVE_MASTER, 8'd0, 13'd0, '{13'd3000, 13'd3000, 13'd1000, 13'd7},
				1'b0, '0},
			'{REQ_GRADE, CURVE_MASTER, 8'd0, 13'd0, '{13'd500, 13'd3000, 13'd3000, 13'd7},
				1'b0, '0},
			'{REQ_GRADE, CURVE_MASTER, 8'd0, 13'd0, '{13'd2048, 13'd2048, 13'd2048, 13'd7},
				1'b0, '0},
			'{REQ_GRADE, CURVE_MASTER, 8'd0, 13'd0, '{13'd0, 13'd0, 13'd1, 13'd7},
				1'b0, '0},
			'{REQ_GRADE, CURVE_MASTER, 8'd0, 13'd0, '{13'd2049, 13'd2048, 13'd2048, 13'd7},
				1'b0, '0},
			'{REQ_LOAD, CURVE_MASTER, 8'd100, 13'h1FFF, '0, 1'b0, '0},
			'{REQ_LOAD, CURVE_RED, 8'd255, 13'd4096, '0, 1'b0, '0},
			'{REQ_LOAD, CURVE_GREEN, 8'd0, 13'd4096, '0, 1'b0, '0},
			'{REQ_LOAD, CURVE_BLUE, 8'd255, 13'd0, '0, 1'b0, '0},
			'{REQ_GRADE, CURVE_MASTER, 8'd0, 13'd0, '{13'd1606, 13'd1606, 13'd1606, 13'd1},
				1'b0, '0},
			'{REQ_GRADE, CURVE_MASTER, 8'd0, 13'd0, '{13'd4096, 13'd4096, 13'd4096, 13'd1},
				1'b0, '0},
			'{REQ_GRADE, CURVE_MASTER, 8'd0, 13'd0, '{13'd0, 13'd0, 13'd0, 13'd1},
				1'b0, '0}
		};
		foreach (rows[i])
			send_beat(rows[i].kind, rows[i].sel, rows[i].idx, rows[i].val, rows[i].px,
				rows[i].typed, rows[i].want);

		// extremes first, then bits outside the legal range, then the reset values, then random settings
		cfg_set = '{
			'{14'd4096, 14'd4096, 14'd8192},
			'{14'h3000, 14'h3000, 14'd0},
			'{14'h1FFF, 14'h2000, 14'h3FFF},
			'{14'h2000, 14'h1FFF, 14'd1},
			'{14'd0, 14'd0, SAT_GAIN_RST},
			'{14'd0, 14'd0, 14'd0},
			'{14'd0, 14'd0, 14'd0},
			'{14'd0, 14'd0, 14'd0}
		};
		for (int ph = 0; ph < 8; ph++) begin
			if (ph >= 5) begin
				cfg_set[ph][0] = 14'($urandom_range(0, 8192) - 4096);
				cfg_set[ph][1] = 14'($urandom_range(0, 8192) - 4096);
				cfg_set[ph][2] = 14'($urandom_range(0, 8192));
			end
			set_regs(cfg_set[ph][0], cfg_set[ph][1], cfg_set[ph][2]);
			if (ph == 7) quiet = 1'b1;
			repeat (78) random_beat();
		end
		s_tvalid <= 1'b0;

		wait (graded_q.size() == 0);
		repeat (LATENCY) @(posedge clk);
		if (fail_cnt == 0)
			$display("** pixel_color_grade: PASSED **");
		else
			$display("** pixel_color_grade: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
